FILE: rtl/dsz_pkg.sv
// ----------------------------------------------------------------------------
// dsz_pkg
// Shared types, register indexes and channel arithmetic for the 2x2 RGBA
// downsampler.
// ----------------------------------------------------------------------------
package dsz_pkg;

    localparam int CHANNELS     = 4;
    localparam int CHAN_W       = 8;
    localparam int SUM_W        = 9;
    localparam int PIXEL_W      = CHANNELS * CHAN_W;
    localparam int PAIR_W       = CHANNELS * SUM_W;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 13;
    localparam int HEIGHT_REG_W = 13;
    localparam int FRAMES_REG_W = 11;
    localparam int ROW_W        = 12;
    localparam int FRAME_W      = 10;

    localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [FRAMES_REG_W-1:0] MAX_FRAMES = 11'd1024;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_COUNT  = 2'd2;

    // position of the current source pixel and the end flags it would carry
    typedef struct packed {
        logic right_col;
        logic odd_row;
        logic row_end;
        logic frame_end;
        logic image_end;
    } pos_info_t;

    typedef struct packed {
        logic image_end;
        logic frame_end;
        logic row_end;
    } end_flags_t;

    // per-channel horizontal sums, 9 bits each, channel 0 lowest
    function automatic logic [PAIR_W-1:0] pair_sums(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b
    );
        logic [PAIR_W-1:0] packed_sum;
        packed_sum = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            packed_sum[k*SUM_W +: SUM_W] = {1'b0, a[k*CHAN_W +: CHAN_W]}
                                         + {1'b0, b[k*CHAN_W +: CHAN_W]};
        end
        return packed_sum;
    endfunction

    // (top + bottom + 2) / 4 per channel, rounded
    function automatic logic [PIXEL_W-1:0] average_block(
        input logic [PAIR_W-1:0] top,
        input logic [PAIR_W-1:0] bottom
    );
        logic [PIXEL_W-1:0] px;
        logic [SUM_W:0]     total;
        px = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            total = {1'b0, top[k*SUM_W +: SUM_W]} + {1'b0, bottom[k*SUM_W +: SUM_W]}
                  + (SUM_W+1)'(2);
            px[k*CHAN_W +: CHAN_W] = total[SUM_W:2];
        end
        return px;
    endfunction

endpackage

FILE: rtl/dsz_ram.sv
// ----------------------------------------------------------------------------
// dsz_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data that only changes on a read.
// ----------------------------------------------------------------------------
module dsz_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 2048
) (
    input  logic                                             clk,
    input  logic                                             wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     wr_addr,
    input  logic [WIDTH-1:0]                                 wr_data,
    input  logic                                             rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]     rd_addr,
    output logic [WIDTH-1:0]                                 rd_data
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/dsz_position.sv
// ----------------------------------------------------------------------------
// dsz_position
// Configuration registers and the column/row/frame position of the stream,
// with line-store slot and end-of-row/frame/image flags for the next pixel.
// ----------------------------------------------------------------------------
module dsz_position #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                                                   clk,
    input  logic                                                   rst_n,
    input  logic                                                   cfg_write,
    input  logic [dsz_pkg::CFG_INDEX_W-1:0]                        cfg_index,
    input  logic [dsz_pkg::CFG_DATA_W-1:0]                         cfg_data,
    input  logic                                                   advance,
    output logic [(((MAX_WIDTH / 2) > 1) ? $clog2(MAX_WIDTH / 2) : 1)-1:0] slot,
    output dsz_pkg::pos_info_t                                     info
);
    import dsz_pkg::*;

    localparam int WW   = $clog2(MAX_WIDTH + 1);
    localparam int CLW  = $clog2(MAX_WIDTH);
    localparam int CMPW = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
    localparam int AW   = ((MAX_WIDTH / 2) > 1) ? $clog2(MAX_WIDTH / 2) : 1;

    logic [CFG_DATA_W-1:0]   image_width_reg, image_width_next;
    logic [HEIGHT_REG_W-1:0] image_height_reg, image_height_next;
    logic [FRAMES_REG_W-1:0] frame_count_reg, frame_count_next;

    logic [CLW-1:0]     column_reg, column_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [FRAME_W-1:0] frame_reg, frame_next;

    logic [CMPW-1:0]         w_ext;
    logic [WW-1:0]           w;
    logic [WW-1:0]           w_even;
    logic [HEIGHT_REG_W-1:0] h;
    logic [HEIGHT_REG_W-1:0] h_even;
    logic [FRAMES_REG_W-1:0] f;
    logic [WW-1:0]           col_inc;
    logic [HEIGHT_REG_W-1:0] row_inc;
    logic [FRAMES_REG_W-1:0] frame_inc;

    // zero acts as one, oversize values saturate
    always_comb
    begin
        w_ext = CMPW'(image_width_reg);
        if (w_ext == '0)
        begin
            w_ext = CMPW'(1);
        end
        else if (w_ext > CMPW'(MAX_WIDTH))
        begin
            w_ext = CMPW'(MAX_WIDTH);
        end
        w = WW'(w_ext);

        h = image_height_reg;
        if (h == '0)
        begin
            h = HEIGHT_REG_W'(1);
        end
        else if (h > MAX_HEIGHT)
        begin
            h = MAX_HEIGHT;
        end

        f = frame_count_reg;
        if (f == '0)
        begin
            f = FRAMES_REG_W'(1);
        end
        else if (f > MAX_FRAMES)
        begin
            f = MAX_FRAMES;
        end
    end

    assign w_even = {w[WW-1:1], 1'b0};
    assign h_even = {h[HEIGHT_REG_W-1:1], 1'b0};

    assign slot = AW'(column_reg >> 1);

    always_comb
    begin
        info.right_col = column_reg[0];
        info.odd_row   = row_reg[0];
        info.row_end   = column_reg[0] && (w_even != '0)
                       && (WW'(column_reg) == w_even - WW'(1));
        info.frame_end = info.row_end && (h_even != '0)
                       && (HEIGHT_REG_W'(row_reg) == h_even - HEIGHT_REG_W'(1));
        info.image_end = info.frame_end
                       && (FRAMES_REG_W'(frame_reg) == f - FRAMES_REG_W'(1));
    end

    always_comb
    begin
        col_inc   = WW'(column_reg) + WW'(1);
        row_inc   = HEIGHT_REG_W'(row_reg) + HEIGHT_REG_W'(1);
        frame_inc = FRAMES_REG_W'(frame_reg) + FRAMES_REG_W'(1);

        column_next = column_reg;
        row_next    = row_reg;
        frame_next  = frame_reg;
        if (advance)
        begin
            if (col_inc >= w)
            begin
                column_next = '0;
                if (row_inc >= h)
                begin
                    row_next = '0;
                    if (frame_inc >= f)
                    begin
                        frame_next = '0;
                    end
                    else
                    begin
                        frame_next = FRAME_W'(frame_inc);
                    end
                end
                else
                begin
                    row_next = ROW_W'(row_inc);
                end
            end
            else
            begin
                column_next = CLW'(col_inc);
            end
        end

        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        frame_count_next  = frame_count_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_data;
                REG_IMAGE_HEIGHT: image_height_next = HEIGHT_REG_W'(cfg_data);
                REG_FRAME_COUNT:  frame_count_next  = FRAMES_REG_W'(cfg_data);
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_DATA_W'(2);
            image_height_reg <= HEIGHT_REG_W'(2);
            frame_count_reg  <= FRAMES_REG_W'(1);
            column_reg       <= '0;
            row_reg          <= '0;
            frame_reg        <= '0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            frame_count_reg  <= frame_count_next;
            column_reg       <= column_next;
            row_reg          <= row_next;
            frame_reg        <= frame_next;
        end
    end

endmodule

FILE: rtl/rgba_half_size_downsampler.sv
// ----------------------------------------------------------------------------
// rgba_half_size_downsampler
// 2x2 box-filter half-size downsampler for RGBA pixel streams.
//
// Source pixels enter on s_axis in raster order, row after row, frame after
// frame; one averaged pixel per 2x2 block leaves on m_axis, with tlast on the
// last pixel of an output row and tuser flagging frame and image ends. An odd
// last column or odd last row of a frame is dropped. Geometry is set through
// the cfg write channel (always ready) while the stream is idle.
// One pixel is accepted per cycle while s_axis_tready is high. A result is
// valid on m_axis once the pixel completing its block is accepted, the line
// store read of the upper pair sums and stage 1 load at the accepting edge,
// and the average is registered into the output register when it advances.
// Pair sums of even rows live in a MAX_WIDTH/2-entry line store.
// When m_axis stalls the output register and one internal stage fill up,
// after which s_axis_tready drops; nothing is lost or repeated.
// Reset clears the position to frame 0, row 0, column 0 and the geometry to
// width 2, height 2, one frame; the line store is not cleared and needs no
// clearing pass, as every entry is written before it is read.
// ----------------------------------------------------------------------------
module rgba_half_size_downsampler #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [dsz_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dsz_pkg::CFG_DATA_W-1:0]    cfg_data,
    // source pixels
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [dsz_pkg::PIXEL_W-1:0]       s_axis_tdata,  // [31:0] pixel_in
    // averaged pixels
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [dsz_pkg::PIXEL_W-1:0]       m_axis_tdata,  // [31:0] pixel_out
    output logic                              m_axis_tlast,  // row_end
    output logic [1:0]                        m_axis_tuser   // [0] frame_end, [1] image_end
);
    import dsz_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH / 2;
    localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

    logic              accept;
    logic [AW-1:0]     slot;
    pos_info_t         info;
    logic [PAIR_W-1:0] pair;
    logic              line_wr;
    logic              line_rd;
    logic [PAIR_W-1:0] line_rd_data;
    logic              out_adv;

    logic [PIXEL_W-1:0] held_left_reg, held_left_next;
    logic               s1_valid_reg, s1_valid_next;
    logic [PAIR_W-1:0]  s1_pair_reg, s1_pair_next;
    end_flags_t         s1_flags_reg, s1_flags_next;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] out_pixel_reg, out_pixel_next;
    end_flags_t         out_flags_reg, out_flags_next;

    assign cfg_ready     = 1'b1;
    assign out_adv       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    dsz_position #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_position (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .slot      (slot),
        .info      (info)
    );

    assign pair    = pair_sums(held_left_reg, s_axis_tdata);
    assign line_wr = accept && info.right_col && !info.odd_row;
    assign line_rd = accept && info.right_col && info.odd_row;

    dsz_ram #(
        .WIDTH (PAIR_W),
        .DEPTH (LINE_DEPTH)
    ) u_line (
        .clk     (clk),
        .wr_en   (line_wr),
        .wr_addr (slot),
        .wr_data (pair),
        .rd_en   (line_rd),
        .rd_addr (slot),
        .rd_data (line_rd_data)
    );

    always_comb
    begin
        held_left_next = held_left_reg;
        if (accept && !info.right_col)
        begin
            held_left_next = s_axis_tdata;
        end

        // stage 1 waits for the upper pair sums from the line store
        s1_valid_next = s1_valid_reg;
        s1_pair_next  = s1_pair_reg;
        s1_flags_next = s1_flags_reg;
        if (out_adv || !s1_valid_reg)
        begin
            s1_valid_next = line_rd;
        end
        if (line_rd)
        begin
            s1_pair_next            = pair;
            s1_flags_next.row_end   = info.row_end;
            s1_flags_next.frame_end = info.frame_end;
            s1_flags_next.image_end = info.image_end;
        end

        out_valid_next = out_valid_reg;
        out_pixel_next = out_pixel_reg;
        out_flags_next = out_flags_reg;
        if (out_adv)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                out_pixel_next = average_block(line_rd_data, s1_pair_reg);
                out_flags_next = s1_flags_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_left_reg <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            held_left_reg <= held_left_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pair_reg   <= s1_pair_next;
        s1_flags_reg  <= s1_flags_next;
        out_pixel_reg <= out_pixel_next;
        out_flags_reg <= out_flags_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_pixel_reg;
    assign m_axis_tlast    = out_flags_reg.row_end;
    assign m_axis_tuser[0] = out_flags_reg.frame_end;
    assign m_axis_tuser[1] = out_flags_reg.image_end;

endmodule

FILE: dv/rgba_half_size_downsampler_tb.sv
// ----------------------------------------------------------------------------
// rgba_half_size_downsampler_tb
// Self-checking bench for the 2x2 RGBA downsampler. A queue-fed driver pushes
// source pixels on s_axis. Every accepted pixel is run through a local
// box-filter model that keeps its own line store, geometry and position, and
// any averaged pixel it yields is queued with its end flags. The monitor
// checks each m_axis transaction against the oldest queued pixel. Geometry is
// changed only with the stream drained and aligned to the start of an even
// row, covering zero, odd, one-pixel and clamped sizes. Both sides
// idle at random, and there is one long output hold under full input load.
// ----------------------------------------------------------------------------
module rgba_half_size_downsampler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dsz_pkg::*;

    localparam int unsigned LINE_SLOTS  = 2048;
    localparam int unsigned MAX_W       = 4096;
    localparam int unsigned MAX_H       = 4096;
    localparam int unsigned MAX_F       = 1024;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN_TAIL  = 8;
    localparam int          LONG_HOLD   = 400;

    // index with no register behind it
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    localparam logic [PIXEL_W-1:0] CORNER_PX [20] = '{
        32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
        32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
        32'h0302_0101, 32'h0001_0100, 32'h0000_0100, 32'h0000_0000,
        32'hFF00_FF01, 32'h00FF_01FF, 32'hFE01_FF00, 32'h01FE_FF80,
        32'h55AA_55AA, 32'hAA55_AA55, 32'h0F0F_0F0F, 32'hF0F0_F0F0
    };

    typedef struct {
        logic [PIXEL_W-1:0] pixel;
        logic               row_end;
        logic               frame_end;
        logic               image_end;
    } avg_pixel_t;

    logic                   clk           = 1'b0;
    logic                   rst_n         = 1'b0;
    logic                   cfg_valid     = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  cfg_data      = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [PIXEL_W-1:0]     s_axis_tdata  = '0;  // [31:0] pixel_in
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [PIXEL_W-1:0]     m_axis_tdata;        // [31:0] pixel_out
    logic                   m_axis_tlast;        // row_end
    logic [1:0]             m_axis_tuser;        // [0] frame_end, [1] image_end

    rgba_half_size_downsampler dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // local box-filter state
    logic [12:0]        width_reg  = 13'd2;
    logic [12:0]        height_reg = 13'd2;
    logic [10:0]        frames_reg = 11'd1;
    logic [PAIR_W-1:0]  upper_sums [LINE_SLOTS];
    logic [PIXEL_W-1:0] left_px    = '0;
    logic [12:0]        col_pos    = '0;
    logic [12:0]        row_pos    = '0;
    logic [10:0]        frame_pos  = '0;

    logic [PIXEL_W-1:0] source_px [$];
    avg_pixel_t         awaited_px [$];
    avg_pixel_t         oldest_px;

    int src_gap_pct   = 23;
    int snk_stall_pct = 23;
    int hold_req      = 0;
    int hold_seen     = 0;
    int hold_left     = 0;
    int fail_count    = 0;

    function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic logic [PAIR_W-1:0] channel_pair_sums(
        input logic [PIXEL_W-1:0] a,
        input logic [PIXEL_W-1:0] b
    );
        logic [PAIR_W-1:0] s;
        s = '0;
        for (int k = 0; k < CHANNELS; k++)
            s[SUM_W*k +: SUM_W] = SUM_W'(a[CHAN_W*k +: CHAN_W]) + SUM_W'(b[CHAN_W*k +: CHAN_W]);
        return s;
    endfunction

    function automatic logic [PIXEL_W-1:0] rounded_block(
        input logic [PAIR_W-1:0] top,
        input logic [PAIR_W-1:0] bottom
    );
        logic [PIXEL_W-1:0] px;
        int unsigned        total;
        px = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            total = top[SUM_W*k +: SUM_W] + bottom[SUM_W*k +: SUM_W] + 2;
            px[CHAN_W*k +: CHAN_W] = CHAN_W'(total >> 2);
        end
        return px;
    endfunction

    // one accepted source pixel: store or combine pair sums, then advance position
    function automatic void predict_downsample(input logic [PIXEL_W-1:0] px);
        int unsigned       w;
        int unsigned       h;
        int unsigned       f;
        int unsigned       slot;
        logic [PAIR_W-1:0] pair;
        avg_pixel_t        res;
        w    = bounded(width_reg, MAX_W);
        h    = bounded(height_reg, MAX_H);
        f    = bounded(frames_reg, MAX_F);
        slot = (col_pos >> 1) % LINE_SLOTS;
        if (!col_pos[0])
            left_px = px;
        else
        begin
            pair = channel_pair_sums(left_px, px);
            if (!row_pos[0])
                upper_sums[slot] = pair;
            else
            begin
                res.pixel     = rounded_block(upper_sums[slot], pair);
                res.row_end   = (col_pos == (w & ~32'd1) - 32'd1);
                res.frame_end = res.row_end && (row_pos == (h & ~32'd1) - 32'd1);
                res.image_end = res.frame_end && (frame_pos == f - 32'd1);
                awaited_px.push_back(res);
            end
        end
        col_pos = col_pos + 13'd1;
        if (col_pos >= w)
        begin
            col_pos = '0;
            row_pos = row_pos + 13'd1;
            if (row_pos >= h)
            begin
                row_pos   = '0;
                frame_pos = frame_pos + 11'd1;
                if (frame_pos >= f)
                    frame_pos = '0;
            end
        end
    endfunction

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] px;
        px = $urandom;
        // a quarter of the pixels get saturated channels
        if ($urandom_range(0, 3) == 0)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                case ($urandom_range(0, 2))
                    0:       px[CHAN_W*k +: CHAN_W] = 8'h00;
                    1:       px[CHAN_W*k +: CHAN_W] = 8'hFF;
                    default: ;
                endcase
            end
        end
        return px;
    endfunction

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("rgba_half_size_downsampler_tb failed");
        $finish;
    end

    // source driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                predict_downsample(s_axis_tdata);
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (source_px.size() > 0 && $urandom_range(0, 99) >= src_gap_pct)
                begin
                    s_axis_tdata  <= source_px.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor and sink back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (awaited_px.size() == 0)
                begin
                    $error("unexpected output pixel %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    oldest_px = awaited_px.pop_front();
                    if (m_axis_tdata !== oldest_px.pixel)
                    begin
                        $error("pixel_out: expected %h, got %h", oldest_px.pixel, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== oldest_px.row_end)
                    begin
                        $error("row_end: expected %b, got %b", oldest_px.row_end, m_axis_tlast);
                        fail_count++;
                    end
                    if (m_axis_tuser[0] !== oldest_px.frame_end)
                    begin
                        $error("frame_end: expected %b, got %b",
                               oldest_px.frame_end, m_axis_tuser[0]);
                        fail_count++;
                    end
                    if (m_axis_tuser[1] !== oldest_px.image_end)
                    begin
                        $error("image_end: expected %b, got %b",
                               oldest_px.image_end, m_axis_tuser[1]);
                        fail_count++;
                    end
                end
            end
            if (hold_seen != hold_req)
            begin
                hold_seen = hold_req;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
            end
        end
    end

    task automatic wait_drained();
        do
            @(negedge clk);
        while (source_px.size() != 0 || s_axis_tvalid || awaited_px.size() != 0);
        // pixels that make no output may still be in the pipe
        repeat (DRAIN_TAIL) @(negedge clk);
    endtask

    task automatic feed_random(input int n);
        repeat (n) source_px.push_back(random_pixel());
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH:  width_reg  = val;
            REG_IMAGE_HEIGHT: height_reg = val;
            REG_FRAME_COUNT:  frames_reg = val[10:0];
            default:          ;
        endcase
    endtask

    // pad the stream out to column 0 of an even row so that no odd row ever
    // reads a line slot left over from a different width
    task automatic align_to_row_pair();
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned next_row;
        w = bounded(width_reg, MAX_W);
        h = bounded(height_reg, MAX_H);
        n = 0;
        if (col_pos != 0 || row_pos[0])
        begin
            n        = w - col_pos;
            next_row = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            if (next_row % 2 != 0)
                n += w;
        end
        feed_random(n);
        wait_drained();
    endtask

    task automatic set_geometry(input int unsigned w, input int unsigned h, input int unsigned f);
        wait_drained();
        align_to_row_pair();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_FRAME_COUNT, CFG_DATA_W'(f));
        @(negedge clk);
    endtask

    initial
    begin
        int unsigned w;
        int unsigned h;
        int unsigned f;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset geometry 2x2, one frame: channel extremes and rounding
        foreach (CORNER_PX[i])
            source_px.push_back(CORNER_PX[i]);

        set_geometry(3, 3, 2);       // odd column and row dropped, image wrap
        feed_random(60);
        set_geometry(1, 4, 2);       // no pair ever completes
        feed_random(40);
        set_geometry(0, 0, 0);       // zeros act as one
        feed_random(20);
        wait_drained();
        write_reg(REG_SPARE, 13'h1FFF);
        @(negedge clk);
        set_geometry(2, 2, 2047);    // frame count clamps to 1024
        feed_random(200);

        // sink held off once results flow, source flat out
        set_geometry(64, 2, 1);
        src_gap_pct = 0;
        feed_random(256);
        do
            @(negedge clk);
        while (awaited_px.size() == 0);
        hold_req++;
        wait_drained();
        src_gap_pct = 23;

        // tall frame with no idling on either side, height clamps to 4096
        set_geometry(2, 8191, 1);
        src_gap_pct   = 0;
        snk_stall_pct = 0;
        feed_random(400);
        wait_drained();
        src_gap_pct   = 23;
        snk_stall_pct = 23;

        for (int p = 0; p < 10; p++)
        begin
            w = (p % 3 == 0) ? $urandom_range(1, 64) : $urandom_range(1, 10);
            h = $urandom_range(1, 9);
            f = $urandom_range(1, 3);
            set_geometry(w, h, f);
            feed_random(50);
            if (p == 4)
                wait_drained();
            feed_random(50);
        end

        wait_drained();
        if (fail_count == 0)
            $display("rgba_half_size_downsampler_tb passed");
        else
            $display("rgba_half_size_downsampler_tb failed");
        $finish;
    end

endmodule
